>>> rtl/text_glyph_square_expander_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text glyph square expander
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_GLYPH_SQUARE_EXPANDER_CORE_MACROS_SVH
`define TEXT_GLYPH_SQUARE_EXPANDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TGSE_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tgse assertion failed");

`define TGSE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tgse assertion failed");

`else

`define TGSE_ASSERT(label, cond)

`define TGSE_ASSERT_IMPL(label, ante, cons)

`endif

`endif

>>> rtl/tgse_pkg.sv
// ---------------------------------------------------------------------------
// tgse_pkg
// Shared types, codes, font table and helpers for the glyph square expander.
// ---------------------------------------------------------------------------
package tgse_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_CHAR  = 2'd0;
	localparam logic [1:0] REQ_LINE  = 2'd1;
	localparam logic [1:0] REQ_FRAME = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
	localparam logic [2:0] REG_DOT_SIZE  = 3'd2;
	localparam logic [2:0] REG_GLYPH_GAP = 3'd3;
	localparam logic [2:0] REG_LINE_GAP  = 3'd4;

	localparam logic [11:0] ORIGIN_X_RST  = 12'd14;
	localparam logic [11:0] ORIGIN_Y_RST  = 12'd14;
	localparam logic [3:0]  DOT_SIZE_RST  = 4'd3;
	localparam logic [5:0]  GLYPH_GAP_RST = 6'd2;
	localparam logic [5:0]  LINE_GAP_RST  = 6'd5;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
	localparam int FONT_DEPTH = 42;

	localparam logic [15:0] COORD_MAX = 16'hFFFF;
	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [3:0]  dot_size;
		logic [5:0]  glyph_gap;
		logic [5:0]  line_gap;
	} cfg_t;

	typedef struct packed {
		logic load_char;
		logic do_line;
		logic do_frame;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bits_empty;
		logic out_free;
	} sts_t;

	// row 0 in the top five bits, each row with its leftmost dot highest
	localparam logic [GLYPH_BITS-1:0] FONT [FONT_DEPTH] = '{
		{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
		{5'd0,  5'd4,  5'd4,  5'd0,  5'd4,  5'd4,  5'd0},
		{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd6,  5'd6},
		{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8},
		{5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0},
		{5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16},
		{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
		{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
		{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
		{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
		{5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
		{5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
		{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
		{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
		{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12},
		{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
		{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
		{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
		{5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12},
		{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
		{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
		{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
		{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
		{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
		{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
		{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
		{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
		{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
		{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
	};

	// ASCII code to font row; lower case folds onto upper case
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		logic [5:0] idx;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
		if (c >= 8'h41 && c <= 8'h5A) begin
			idx = 6'(c - 8'h41) + 6'd16;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			idx = 6'(c - 8'h30) + 6'd6;
		end else begin
			case (c)
				8'h3A: idx = 6'd1;   // colon
				8'h2E: idx = 6'd2;   // period
				8'h2C: idx = 6'd3;   // comma
				8'h2D: idx = 6'd4;   // dash
				8'h2F: idx = 6'd5;   // slash
				default: idx = 6'd0;
			endcase
		end
		return idx;
	endfunction

	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
		logic [5:0] idx;
		idx = glyph_index(code);
		return FONT[idx];
	endfunction

	function automatic logic [15:0] sat16(input logic [16:0] v);
		return v[16] ? COORD_MAX : v[15:0];
	endfunction

endpackage

>>> rtl/text_glyph_square_expander_core.sv
// ---------------------------------------------------------------------------
// text_glyph_square_expander_core
// 5x7 bitmap font character generator emitting one word per filled dot.
// ---------------------------------------------------------------------------
// A character word is taken, then its glyph is scanned one dot position per
// cycle while the output register has room, top row first and leftmost dot
// first, up to the last set dot, followed by a step that moves the cursor.
// A new-line or new-frame word is acted on as it is taken. The scan holds
// whenever the output register is full and not being taken. The next input
// word is taken as soon as the scan of the previous one ends.
module text_glyph_square_expander_core
	import tgse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // char_code[7:0]
	input  logic [1:0]  s_tuser,    // req_type[1:0]
	// square stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // square_x[15:0], square_y[31:16], square_number[55:32]
	output logic        m_tlast     // last_of_glyph
);

`include "text_glyph_square_expander_core_macros.svh"

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tgse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tgse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.char_code (s_tdata),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// between characters no dots may be left in the shifter
	`TGSE_ASSERT_IMPL(a_idle_no_dots, s_tready, sts.bits_empty)
	// at most one datapath command per cycle
	`TGSE_ASSERT(a_cmd_onehot0, $onehot0(cmd))
	// a scan step never overwrites a square still waiting at the output
	`TGSE_ASSERT_IMPL(a_step_room, cmd.step, !m_tvalid || m_tready)

endmodule

>>> rtl/tgse_regs.sv
// ---------------------------------------------------------------------------
// tgse_regs
// APB register file holding origin, dot size and gap settings.
// ---------------------------------------------------------------------------
module tgse_regs
	import tgse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= ORIGIN_X_RST;
			cfg_q.origin_y  <= ORIGIN_Y_RST;
			cfg_q.dot_size  <= DOT_SIZE_RST;
			cfg_q.glyph_gap <= GLYPH_GAP_RST;
			cfg_q.line_gap  <= LINE_GAP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ORIGIN_X:  cfg_q.origin_x  <= pwdata[11:0];
				REG_ORIGIN_Y:  cfg_q.origin_y  <= pwdata[11:0];
				REG_DOT_SIZE:  cfg_q.dot_size  <= pwdata[3:0];
				REG_GLYPH_GAP: cfg_q.glyph_gap <= pwdata[5:0];
				REG_LINE_GAP:  cfg_q.line_gap  <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ORIGIN_X:  prdata = {20'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:  prdata = {20'd0, cfg_q.origin_y};
			REG_DOT_SIZE:  prdata = {28'd0, cfg_q.dot_size};
			REG_GLYPH_GAP: prdata = {26'd0, cfg_q.glyph_gap};
			REG_LINE_GAP:  prdata = {26'd0, cfg_q.line_gap};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/tgse_ctrl.sv
// ---------------------------------------------------------------------------
// tgse_ctrl
// Request sequencer: takes one word, then for a character steps the dot scan to its end.
// ---------------------------------------------------------------------------
module tgse_ctrl
	import tgse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] s_tuser,
	output logic       s_tready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						REQ_CHAR: begin
							cmd.load_char = 1'b1;
							state_d       = ST_SCAN;
						end
						REQ_LINE:  cmd.do_line  = 1'b1;
						REQ_FRAME: cmd.do_frame = 1'b1;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				// no dots left: move the cursor and take the next word
				if (sts.bits_empty) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/tgse_dp.sv
// ---------------------------------------------------------------------------
// tgse_dp
// Cursor, square count, glyph dot shifter and output register.
// ---------------------------------------------------------------------------
module tgse_dp
	import tgse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	input  logic [7:0]  char_code,
	output sts_t        sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // square_x[15:0], square_y[31:16], square_number[55:32]
	output logic        m_tlast
);

	logic [15:0]           cursor_x_q;
	logic [15:0]           cursor_y_q;
	logic [23:0]           count_q;
	logic [GLYPH_BITS-1:0] bits_q;     // remaining dots in scan order, next dot at MSB
	logic [2:0]            col_q;
	logic [5:0]            x_off_q;    // col * dot_size
	logic [6:0]            y_off_q;    // row * dot_size
	logic                  out_vld_q;
	logic [15:0]           sq_x_q;
	logic [15:0]           sq_y_q;
	logic [23:0]           sq_num_q;
	logic                  sq_last_q;

	logic [GLYPH_BITS-1:0] bits_nxt;
	logic                  emit;
	logic [7:0]            adv_x;
	logic [7:0]            adv_y;

	assign bits_nxt = {bits_q[GLYPH_BITS-2:0], 1'b0};
	assign emit     = cmd.step & bits_q[GLYPH_BITS-1];
	// 5*dot + glyph_gap and 7*dot + line_gap
	assign adv_x    = 8'({cfg.dot_size, 2'b00}) + 8'(cfg.dot_size) + 8'(cfg.glyph_gap);
	assign adv_y    = 8'({cfg.dot_size, 3'b000}) - 8'(cfg.dot_size) + 8'(cfg.line_gap);

	assign sts.bits_empty = (bits_q == '0);
	assign sts.out_free   = ~out_vld_q | m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {sq_num_q, sq_y_q, sq_x_q};
	assign m_tlast  = sq_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= 16'(ORIGIN_X_RST);
			cursor_y_q <= 16'(ORIGIN_Y_RST);
			count_q    <= '0;
			bits_q     <= '0;
			col_q      <= '0;
			x_off_q    <= '0;
			y_off_q    <= '0;
		end else begin
			if (cmd.load_char) begin
				bits_q  <= glyph_bits(char_code);
				col_q   <= '0;
				x_off_q <= '0;
				y_off_q <= '0;
			end
			if (cmd.step) begin
				bits_q <= bits_nxt;
				if (col_q == 3'(GLYPH_COLS - 1)) begin
					col_q   <= '0;
					x_off_q <= '0;
					y_off_q <= y_off_q + 7'(cfg.dot_size);
				end else begin
					col_q   <= col_q + 3'd1;
					x_off_q <= x_off_q + 6'(cfg.dot_size);
				end
			end
			if (emit && count_q != COUNT_MAX) begin
				count_q <= count_q + 24'd1;
			end
			if (cmd.finish) begin
				cursor_x_q <= sat16({1'b0, cursor_x_q} + 17'(adv_x));
			end
			if (cmd.do_line) begin
				cursor_x_q <= 16'(cfg.origin_x);
				cursor_y_q <= sat16({1'b0, cursor_y_q} + 17'(adv_y));
			end
			if (cmd.do_frame) begin
				cursor_x_q <= 16'(cfg.origin_x);
				cursor_y_q <= 16'(cfg.origin_y);
				count_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sq_x_q    <= sat16({1'b0, cursor_x_q} + 17'(x_off_q));
			sq_y_q    <= sat16({1'b0, cursor_y_q} + 17'(y_off_q));
			sq_num_q  <= count_q;
			sq_last_q <= (bits_nxt == '0);
		end
	end

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for text_glyph_square_expander_core
// Drives character, new-line and new-frame requests through the stream
// port, reprograms the layout registers between phases and checks every
// square word against an in-bench model of the 5x7 font, the cursor and the
// square count, including zero dot size and extreme layout settings.
// ---------------------------------------------------------------------------
module tb;
	import tgse_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [23:0] number;
		logic        last;
	} square_t;

	class glyph_tracker;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [3:0]  dot_size;
		logic [5:0]  glyph_gap;
		logic [5:0]  line_gap;
		int unsigned cursor_x;
		int unsigned cursor_y;
		int unsigned square_count;
		square_t     pending_squares[$];
		int          errors;
		int          checked;

		function new();
			origin_x = 12'd14;
			origin_y = 12'd14;
			dot_size = 4'd3;
			glyph_gap = 6'd2;
			line_gap = 6'd5;
			cursor_x = 14;
			cursor_y = 14;
			square_count = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_ORIGIN_X:  origin_x = v[11:0];
				REG_ORIGIN_Y:  origin_y = v[11:0];
				REG_DOT_SIZE:  dot_size = v[3:0];
				REG_GLYPH_GAP: glyph_gap = v[5:0];
				REG_LINE_GAP:  line_gap = v[5:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] register_value(logic [2:0] idx);
			case (idx)
				REG_ORIGIN_X:  return {20'd0, origin_x};
				REG_ORIGIN_Y:  return {20'd0, origin_y};
				REG_DOT_SIZE:  return {28'd0, dot_size};
				REG_GLYPH_GAP: return {26'd0, glyph_gap};
				REG_LINE_GAP:  return {26'd0, line_gap};
				default:       return 32'd0;
			endcase
		endfunction

		function int unsigned clamp_coord(int unsigned v);
			return (v > COORD_MAX) ? COORD_MAX : v;
		endfunction

		function int glyph_slot(logic [7:0] code);
			logic [7:0] c;
			c = code;
			if (c >= "a" && c <= "z") c = c - 8'd32;
			if (c >= "A" && c <= "Z") return 16 + int'(c - "A");
			if (c >= "0" && c <= "9") return 6 + int'(c - "0");
			case (c)
				":": return 1;
				".": return 2;
				",": return 3;
				"-": return 4;
				"/": return 5;
				default: return 0;
			endcase
		endfunction

		// row 0 in the top five bits, leftmost dot of each row highest
		function logic [34:0] glyph_pattern(int slot);
			case (slot)
				1:  return {5'd0, 5'd4, 5'd4, 5'd0, 5'd4, 5'd4, 5'd0};
				2:  return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd6};
				3:  return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd8};
				4:  return {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
				5:  return {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
				6:  return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
				7:  return {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
				8:  return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
				9:  return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
				10: return {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
				11: return {5'd31, 5'd16, 5'd30, 5'd1, 5'd1, 5'd17, 5'd14};
				12: return {5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
				13: return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
				14: return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
				15: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd12};
				16: return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
				17: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
				18: return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
				19: return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
				20: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
				21: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
				22: return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
				23: return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
				24: return {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
				25: return {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
				26: return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
				27: return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
				28: return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
				29: return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
				30: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
				31: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
				32: return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
				33: return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
				34: return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
				35: return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
				36: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
				37: return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
				38: return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
				39: return {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
				40: return {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
				41: return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
				default: return 35'd0;
			endcase
		endfunction

		// called at the edge that accepts a request word
		function void take_request(logic [1:0] req, logic [7:0] code);
			logic [34:0] dots;
			square_t     sq;
			int          n;
			n = 0;
			case (req)
				REQ_LINE: begin
					cursor_x = origin_x;
					cursor_y = clamp_coord(cursor_y + 7 * dot_size + line_gap);
				end
				REQ_FRAME: begin
					cursor_x = origin_x;
					cursor_y = origin_y;
					square_count = 0;
				end
				REQ_CHAR: begin
					dots = glyph_pattern(glyph_slot(code));
					for (int r = 0; r < 7; r++) begin
						for (int c = 0; c < 5; c++) begin
							if (dots[34 - (r * 5 + c)]) begin
								sq.x = 16'(clamp_coord(cursor_x + c * dot_size));
								sq.y = 16'(clamp_coord(cursor_y + r * dot_size));
								sq.number = 24'(square_count);
								sq.last = 1'b0;
								pending_squares = {pending_squares, sq};
								if (square_count < COUNT_MAX) square_count++;
								n++;
							end
						end
					end
					if (n > 0) begin
						pending_squares[pending_squares.size() - 1].last = 1'b1;
					end
					cursor_x = clamp_coord(cursor_x + 5 * dot_size + glyph_gap);
				end
				default: ;
			endcase
		endfunction

		function void check_square(logic [55:0] data, logic last);
			square_t want;
			if (pending_squares.size() == 0) begin
				$error("unexpected square word: x=%0d y=%0d number=%0d last=%0b",
					data[15:0], data[31:16], data[55:32], last);
				errors++;
				return;
			end
			want = pending_squares.pop_front();
			checked++;
			if (data[15:0] !== want.x) begin
				$error("square_x: expected %0d, actual %0d", want.x, data[15:0]);
				errors++;
			end
			if (data[31:16] !== want.y) begin
				$error("square_y: expected %0d, actual %0d", want.y, data[31:16]);
				errors++;
			end
			if (data[55:32] !== want.number) begin
				$error("square_number: expected %0d, actual %0d", want.number, data[55:32]);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_glyph: expected %0b, actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // char_code[7:0]
	logic [1:0]  s_tuser;    // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;    // square_x[15:0], square_y[31:16], square_number[55:32]
	logic        m_tlast;

	glyph_tracker tracker;
	bit           steady;
	bit           hold_off_req;
	int unsigned  cycle_count;
	int           sent_words;
	int           ignored_words;
	int           reg_writes;

	text_glyph_square_expander_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_square(m_tdata, m_tlast);
	end

	// sink side: random back-pressure, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= steady || ($urandom_range(99) >= 10);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [1:0] req, input logic [7:0] code);
		if (!steady && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= code;
		do @(posedge clk); while (!s_tready);
		tracker.take_request(req, code);
		if (req == REQ_UNUSED) ignored_words++;
		else sent_words++;
		@(negedge clk);
	endtask

	// blank glyphs and new lines leave no word behind, so allow a few extra cycles
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_squares.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(idx, value);
		reg_writes++;
		@(negedge clk);
		// read back through a second transfer
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== tracker.register_value(idx)) begin
			$error("register %0d readback: expected %0d, actual %0d",
				idx, tracker.register_value(idx), prdata);
			tracker.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [11:0] ox, input logic [11:0] oy,
		input logic [3:0] dot, input logic [5:0] gg, input logic [5:0] lg);
		write_register(REG_ORIGIN_X, {20'd0, ox});
		write_register(REG_ORIGIN_Y, {20'd0, oy});
		write_register(REG_DOT_SIZE, {28'd0, dot});
		write_register(REG_GLYPH_GAP, {26'd0, gg});
		write_register(REG_LINE_GAP, {26'd0, lg});
	endtask

	// mostly text lines with printable characters, some noise words
	task automatic random_run(input int count);
		string       charset;
		int          done;
		int          roll;
		logic [7:0]  code;
		charset = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789:.,-/ ";
		done = 0;
		while (done < count) begin
			roll = $urandom_range(99);
			code = 8'($urandom_range(255));
			if (roll < 4) begin
				send_request(REQ_FRAME, code);
			end else if (roll < 13) begin
				send_request(REQ_LINE, code);
			end else if (roll < 16) begin
				send_request(REQ_UNUSED, code);
				continue;
			end else if (roll < 28) begin
				send_request(REQ_CHAR, code);
			end else begin
				send_request(REQ_CHAR, 8'(charset[$urandom_range(charset.len() - 1)]));
			end
			done++;
		end
	endtask

	initial begin
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_CHAR;
		m_tready = 1'b0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		cycle_count = 0;
		sent_words = 0;
		ignored_words = 0;
		reg_writes = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every glyph class, code extremes, all request kinds
		send_request(REQ_CHAR, "A");
		send_request(REQ_CHAR, "z");
		send_request(REQ_CHAR, "0");
		send_request(REQ_CHAR, "9");
		send_request(REQ_CHAR, ":");
		send_request(REQ_CHAR, ".");
		send_request(REQ_CHAR, ",");
		send_request(REQ_CHAR, "-");
		send_request(REQ_CHAR, "/");
		send_request(REQ_CHAR, " ");
		send_request(REQ_CHAR, 8'h00);
		send_request(REQ_CHAR, 8'hFF);
		send_request(REQ_CHAR, "@");
		send_request(REQ_CHAR, 8'h80);
		send_request(REQ_CHAR, "8");
		send_request(REQ_LINE, 8'hFF);
		send_request(REQ_CHAR, "W");
		send_request(REQ_UNUSED, "A");
		send_request(REQ_CHAR, "m");
		send_request(REQ_FRAME, 8'h5A);
		send_request(REQ_CHAR, "B");
		send_request(REQ_UNUSED, 8'h00);
		send_request(REQ_CHAR, "q");
		drain();

		// origin change alone does not move the cursor
		configure(12'd200, 12'd100, 4'd2, 6'd1, 6'd0);
		random_run(50);
		drain();

		// all fields at their maximum, sink stalled long at the start
		configure(12'd4095, 12'd4095, 4'd15, 6'd63, 6'd63);
		hold_off_req = 1'b1;
		random_run(50);
		drain();

		// minimum layout with dot size one, no idling on either side
		steady = 1'b1;
		configure(12'd0, 12'd0, 4'd1, 6'd0, 6'd0);
		random_run(50);
		drain();
		steady = 1'b0;

		// zero dot size: all squares of a glyph on the cursor
		configure(12'($urandom_range(4095)), 12'($urandom_range(4095)), 4'd0,
			6'($urandom_range(63)), 6'($urandom_range(63)));
		random_run(40);
		drain();

		configure(12'($urandom_range(4095)), 12'($urandom_range(4095)),
			4'($urandom_range(15, 1)), 6'($urandom_range(63)), 6'($urandom_range(63)));
		random_run(30);
		drain();

		$display("run covered %0d request words (%0d unused kind), %0d squares checked,",
			sent_words + ignored_words, ignored_words, tracker.checked);
		$display("%0d register writes with readback, zero dot size and extreme layouts",
			reg_writes);
		if (tracker.errors == 0 && tracker.pending_squares.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/tgse_pkg.sv
rtl/tgse_regs.sv
rtl/tgse_ctrl.sv
rtl/tgse_dp.sv
rtl/text_glyph_square_expander_core.sv
sim/tb.sv
